>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Implication checks on the rising clock edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/wmv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmv_pkg
// Shared types, constants and helper functions of the vertex generator.
// ----------------------------------------------------------------------------
package wmv_pkg;

  localparam int unsigned BUF_SAMPLES  = 512;
  localparam int unsigned MAX_VERTICES = 128;
  localparam int unsigned RIGHT_LEAD   = 25;

  localparam int unsigned ADDR_W    = $clog2(BUF_SAMPLES);
  localparam int unsigned SUM_W     = ADDR_W + 2;
  localparam int unsigned N_W       = 8;
  localparam int unsigned IDX_W     = 7;
  localparam int unsigned SIDX_W    = 9;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned VW_W      = 14;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_W     = 16;

  localparam int unsigned N_BASE = (BUF_SAMPLES < MAX_VERTICES) ? BUF_SAMPLES : MAX_VERTICES;
  localparam int unsigned N_MIN  = 32;

  // width/6 by reciprocal, exact for every width below 3*N_BASE
  localparam int unsigned DIV6_MUL   = 683;
  localparam int unsigned DIV6_SHIFT = 12;
  localparam int unsigned SMALL_VW_W = $clog2(3 * N_BASE);
  localparam int unsigned SIX_PROD_W = SMALL_VW_W + DIV6_SHIFT;

  // ramp quotient bits: (i << RAMP_W) / n
  localparam int unsigned RAMP_W    = 14;
  localparam int unsigned RAMP_BIAS = 8192;
  localparam int unsigned DCNT_W    = $clog2(RAMP_W + 1);
  localparam int unsigned REM_W     = N_W + 1;

  // shared multiplier
  localparam int unsigned OP_W       = 19;
  localparam int unsigned PROD_W     = 2 * OP_W;
  localparam int unsigned ACC_W      = PROD_W + 2;
  localparam int unsigned FRAC_SHIFT = 17;
  localparam int unsigned SH_W       = ACC_W - FRAC_SHIFT;

  localparam int unsigned C_RIGHT = 14418;
  localparam int unsigned C_LEFT  = 15401;
  localparam int unsigned W1_BASE = 91750;
  localparam int unsigned W_ONE   = 131072;

  localparam logic signed [OP_W-1:0] SAT_HI = OP_W'(32767);
  localparam logic signed [OP_W-1:0] SAT_LO = -OP_W'(32768);
  localparam logic signed [SH_W-1:0] BLEND_HI = SH_W'(16384);
  localparam logic signed [SH_W-1:0] BLEND_LO = -SH_W'(16384);

  localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PARAM    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_X   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_Y   = CFG_IDX_W'(3);

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_VERTEX = 1'b1;

  typedef struct packed {
    logic                       req_type;
    logic [SIDX_W-1:0]          sample_index;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic [IDX_W-1:0]           vertex_index;
  } wmv_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic [N_W-1:0]            active_count;
    logic                      in_range;
  } wmv_res_t;

  typedef struct packed {
    logic                   en;
    logic                   clr;
    logic signed [OP_W-1:0] a;
    logic signed [OP_W-1:0] b;
  } wmv_mac_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CALC
  } wmv_state_e;

  function automatic logic [N_W-1:0] calc_active(input logic [VW_W-1:0] vw);
    logic [SIX_PROD_W-1:0] prod;
    logic [N_W-1:0]        sixth;
    prod  = SIX_PROD_W'(vw[SMALL_VW_W-1:0]) * SIX_PROD_W'(DIV6_MUL);
    sixth = N_W'(prod >> DIV6_SHIFT);
    if (vw >= VW_W'(3 * N_BASE)) begin
      return N_W'(N_BASE);
    end else if (sixth < N_W'(N_MIN)) begin
      return N_W'(N_MIN);
    end
    return sixth;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [OP_W-1:0] v);
    if (v > SAT_HI) begin
      return COORD_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      return COORD_W'(SAT_LO);
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_blend(input logic signed [SH_W-1:0] v);
    if (v > BLEND_HI) begin
      return COORD_W'(BLEND_HI);
    end else if (v < BLEND_LO) begin
      return COORD_W'(BLEND_LO);
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

>>> src/waveform_momentum_vertex_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_momentum_vertex_gen
// Stereo sample store plus a sequenced vertex datapath: an iterative divider
// for the ramp and one shared multiply-accumulate unit for the sample scaling
// and the momentum blend.
//
//   channel   direction  handshake                 word
//   request   in         start_i / busy_o          req_i
//   result    out        res_valid_o (strobe)      res_o
//   config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A load word is written in the cycle it is accepted; busy_o stays low.
// A vertex in range passes first through the bit-serial ramp divider, then
// through up to 10 steps of the shared multiplier; vertices 0 and 1 end
// after the Y0 step, before the blend. A vertex out of range strobes next cycle.
// Reset clears control, history and configuration; the sample store has
// no reset. The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module waveform_momentum_vertex_gen (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  wmv_pkg::wmv_req_t                 req_i,
  output logic                              res_valid_o,
  output wmv_pkg::wmv_res_t                 res_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wmv_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wmv_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned OP_W   = wmv_pkg::OP_W;
  localparam int unsigned SW     = wmv_pkg::SAMPLE_W;
  localparam int unsigned CW     = wmv_pkg::COORD_W;
  localparam int unsigned STEP_W = 4;

  localparam logic [STEP_W-1:0] STEP_MUL_R = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_MUL_L = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_X0    = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_Y0    = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_BX1   = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_BX2   = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_BY1   = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_BY2   = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_WAIT  = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(9);

  // configuration
  logic [wmv_pkg::VW_W-1:0] vw_q;
  logic signed [SW-1:0]     mp_q, wx_q, wy_q;
  logic                     cfg_we;

  // control
  wmv_pkg::wmv_state_e      state_q, state_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic                     accept, vtx_ok, last_step;
  logic [wmv_pkg::N_W-1:0]  n_cur;

  // sample store
  logic [SW-1:0]            left_mem  [wmv_pkg::BUF_SAMPLES];
  logic [SW-1:0]            right_mem [wmv_pkg::BUF_SAMPLES];
  logic signed [SW-1:0]     rd_l_q, rd_r_q;
  logic                     wr_en, rd_en;
  logic [wmv_pkg::SUM_W-1:0]  off, li_sum, ri_sum;
  logic [wmv_pkg::ADDR_W-1:0] li, ri;

  // datapath
  logic [wmv_pkg::IDX_W-1:0]  idx_q;
  logic signed [CW-1:0]       xc_q, xc_d, yc_q, yc_d, xb_q, xb_d;
  logic signed [CW-1:0]       px_q, px_d, py_q, py_d, ppx_q, ppx_d, ppy_q, ppy_d;
  logic                       res_valid_q, res_valid_d;
  wmv_pkg::wmv_res_t          res_q, res_d;
  logic                       fin;
  logic signed [CW-1:0]       fin_x, fin_y;

  // shared units
  logic                       div_start, div_busy;
  logic [wmv_pkg::RAMP_W-1:0] div_quo;
  wmv_pkg::wmv_mac_cmd_t      mac_cmd;
  logic signed [wmv_pkg::ACC_W-1:0] mac_acc, acc_rnd;
  logic signed [wmv_pkg::SH_W-1:0]  acc_sh;

  logic signed [OP_W-1:0] ramp, x_sum, y_sum, w1, w2, mom_x, mom_y;
  logic signed [OP_W-1:0] wx_ext, wy_ext, mp_ext, xc_ext, yc_ext, l_ext, r_ext;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vw_q <= wmv_pkg::VW_W'(1920);
      mp_q <= '0;
      wx_q <= '0;
      wy_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        wmv_pkg::CFG_VIEWPORT: vw_q <= cfg_data_i[wmv_pkg::VW_W-1:0];
        wmv_pkg::CFG_PARAM:    mp_q <= cfg_data_i;
        wmv_pkg::CFG_WAVE_X:   wx_q <= cfg_data_i;
        wmv_pkg::CFG_WAVE_Y:   wy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign n_cur = wmv_pkg::calc_active(vw_q);

  // ---------------------------------------------------------------- store
  assign accept = start_i & ~busy_o;
  assign vtx_ok = ({1'b0, req_i.vertex_index} < n_cur);
  assign wr_en  = accept & (req_i.req_type == wmv_pkg::REQ_LOAD) &
                  ({1'b0, req_i.sample_index} < (wmv_pkg::SIDX_W + 1)'(wmv_pkg::BUF_SAMPLES));
  assign rd_en  = accept & (req_i.req_type == wmv_pkg::REQ_VERTEX) & vtx_ok;

  // center the window, clamp both taps to the last entry
  assign off    = (wmv_pkg::SUM_W'(wmv_pkg::BUF_SAMPLES) - wmv_pkg::SUM_W'(n_cur)) >> 1;
  assign li_sum = wmv_pkg::SUM_W'(req_i.vertex_index) + off;
  assign ri_sum = li_sum + wmv_pkg::SUM_W'(wmv_pkg::RIGHT_LEAD);
  assign li = (li_sum > wmv_pkg::SUM_W'(wmv_pkg::BUF_SAMPLES - 1)) ?
              wmv_pkg::ADDR_W'(wmv_pkg::BUF_SAMPLES - 1) : li_sum[wmv_pkg::ADDR_W-1:0];
  assign ri = (ri_sum > wmv_pkg::SUM_W'(wmv_pkg::BUF_SAMPLES - 1)) ?
              wmv_pkg::ADDR_W'(wmv_pkg::BUF_SAMPLES - 1) : ri_sum[wmv_pkg::ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      left_mem[req_i.sample_index[wmv_pkg::ADDR_W-1:0]]  <= req_i.left_sample;
      right_mem[req_i.sample_index[wmv_pkg::ADDR_W-1:0]] <= req_i.right_sample;
    end
    if (rd_en) begin
      rd_l_q <= left_mem[li];
      rd_r_q <= right_mem[ri];
    end
  end

  // ---------------------------------------------------------------- units
  assign div_start = rd_en;

  wmv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (req_i.vertex_index),
    .den_i   (n_cur),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  wmv_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .acc_o  (mac_acc)
  );

  assign acc_rnd = mac_acc + wmv_pkg::ACC_W'(1 << (wmv_pkg::FRAC_SHIFT - 1));
  assign acc_sh  = acc_rnd[wmv_pkg::ACC_W-1:wmv_pkg::FRAC_SHIFT];

  assign wx_ext = {{(OP_W - SW){wx_q[SW-1]}}, wx_q};
  assign wy_ext = {{(OP_W - SW){wy_q[SW-1]}}, wy_q};
  assign mp_ext = {{(OP_W - SW){mp_q[SW-1]}}, mp_q};
  assign xc_ext = {{(OP_W - CW){xc_q[CW-1]}}, xc_q};
  assign yc_ext = {{(OP_W - CW){yc_q[CW-1]}}, yc_q};
  assign l_ext  = {{(OP_W - SW){rd_l_q[SW-1]}}, rd_l_q};
  assign r_ext  = {{(OP_W - SW){rd_r_q[SW-1]}}, rd_r_q};

  assign ramp  = {{(OP_W - wmv_pkg::RAMP_W){1'b0}}, div_quo} - OP_W'(wmv_pkg::RAMP_BIAS);
  assign x_sum = ramp + wx_ext + acc_sh[OP_W-1:0];
  assign y_sum = acc_sh[OP_W-1:0] + wy_ext;

  assign w1 = OP_W'(wmv_pkg::W1_BASE) + mp_ext;
  assign w2 = OP_W'(wmv_pkg::W_ONE) - w1;

  // extrapolated point: 2*prev - prevprev
  assign mom_x = ({{(OP_W - CW){px_q[CW-1]}}, px_q} <<< 1) - {{(OP_W - CW){ppx_q[CW-1]}}, ppx_q};
  assign mom_y = ({{(OP_W - CW){py_q[CW-1]}}, py_q} <<< 1) - {{(OP_W - CW){ppy_q[CW-1]}}, ppy_q};

  // ---------------------------------------------------------------- FSM
  assign busy_o    = (state_q != wmv_pkg::ST_IDLE);
  assign last_step = (step_q == STEP_LAST) ||
                     ((step_q == STEP_Y0) && (idx_q < wmv_pkg::IDX_W'(2)));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wmv_pkg::ST_IDLE: if (rd_en)     state_d = wmv_pkg::ST_DIV;
      wmv_pkg::ST_DIV:  if (!div_busy) state_d = wmv_pkg::ST_CALC;
      wmv_pkg::ST_CALC: if (last_step) state_d = wmv_pkg::ST_IDLE;
      default:          state_d = wmv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    step_d      = '0;
    mac_cmd     = '0;
    xc_d        = xc_q;
    yc_d        = yc_q;
    xb_d        = xb_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    fin         = 1'b0;
    fin_x       = xc_q;
    fin_y       = yc_q;
    px_d        = px_q;
    py_d        = py_q;
    ppx_d       = ppx_q;
    ppy_d       = ppy_q;

    unique case (state_q)
      wmv_pkg::ST_IDLE: begin
        // out-of-range vertex: report right away, leave history alone
        if (accept && (req_i.req_type == wmv_pkg::REQ_VERTEX) && !vtx_ok) begin
          res_valid_d        = 1'b1;
          res_d.vertex_x     = '0;
          res_d.vertex_y     = '0;
          res_d.active_count = n_cur;
          res_d.in_range     = 1'b0;
        end
      end
      wmv_pkg::ST_DIV: ;
      wmv_pkg::ST_CALC: begin
        step_d = step_q + 1'b1;
        case (step_q)
          STEP_MUL_R: mac_cmd = '{en: 1'b1, clr: 1'b1, a: r_ext, b: OP_W'(wmv_pkg::C_RIGHT)};
          STEP_MUL_L: mac_cmd = '{en: 1'b1, clr: 1'b1, a: l_ext, b: OP_W'(wmv_pkg::C_LEFT)};
          STEP_X0:    xc_d = wmv_pkg::sat_coord(x_sum);
          STEP_Y0: begin
            yc_d = wmv_pkg::sat_coord(y_sum);
            if (last_step) begin
              fin   = 1'b1;
              fin_x = xc_q;
              fin_y = yc_d;
            end
          end
          STEP_BX1:   mac_cmd = '{en: 1'b1, clr: 1'b1, a: xc_ext, b: w2};
          STEP_BX2:   mac_cmd = '{en: 1'b1, clr: 1'b0, a: w1, b: mom_x};
          STEP_BY1:   mac_cmd = '{en: 1'b1, clr: 1'b1, a: yc_ext, b: w2};
          STEP_BY2: begin
            mac_cmd = '{en: 1'b1, clr: 1'b0, a: w1, b: mom_y};
            xb_d    = wmv_pkg::clamp_blend(acc_sh);
          end
          STEP_WAIT:  ;
          STEP_LAST: begin
            fin   = 1'b1;
            fin_x = xb_q;
            fin_y = wmv_pkg::clamp_blend(acc_sh);
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // retire an in-range vertex: shift history, emit the word
    if (fin) begin
      ppx_d              = px_q;
      ppy_d              = py_q;
      px_d               = fin_x;
      py_d               = fin_y;
      res_valid_d        = 1'b1;
      res_d.vertex_x     = fin_x;
      res_d.vertex_y     = fin_y;
      res_d.active_count = n_cur;
      res_d.in_range     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wmv_pkg::ST_IDLE;
      step_q      <= '0;
      res_valid_q <= 1'b0;
      px_q        <= '0;
      py_q        <= '0;
      ppx_q       <= '0;
      ppy_q       <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      res_valid_q <= res_valid_d;
      px_q        <= px_d;
      py_q        <= py_d;
      ppx_q       <= ppx_d;
      ppy_q       <= ppy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      idx_q <= req_i.vertex_index;
    end
    xc_q  <= xc_d;
    yc_q  <= yc_d;
    xb_q  <= xb_d;
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // ---------------------------------------------------------------- checks
  `ASSERT_IMPLY(a_inrange_from_calc, clk_i, rst_ni, res_valid_o && res_o.in_range, $past(state_q == wmv_pkg::ST_CALC), "in-range word without a finished calculation")
  `ASSERT_IMPLY(a_oor_zero, clk_i, rst_ni, res_valid_o && !res_o.in_range, res_o.vertex_x == 0 && res_o.vertex_y == 0, "out-of-range word has nonzero coordinates")
  `ASSERT_NEXT(a_vertex_busy, clk_i, rst_ni, rd_en, busy_o && div_busy, "accepted vertex did not start the divider")
  `ASSERT_IMPLY(a_calc_after_div, clk_i, rst_ni, state_q == wmv_pkg::ST_CALC, !div_busy, "calculation running while divider busy")

endmodule

>>> src/wmv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmv_div
// Restoring divider for the ramp term: quotient = (num << RAMP_W) / den,
// one quotient bit per cycle. Requires num < den.
// ----------------------------------------------------------------------------
module wmv_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [wmv_pkg::IDX_W-1:0]           num_i,
  input  logic [wmv_pkg::N_W-1:0]             den_i,
  output logic                                busy_o,
  output logic [wmv_pkg::RAMP_W-1:0]          quo_o
);

  logic [wmv_pkg::DCNT_W-1:0] cnt_q, cnt_d;
  logic [wmv_pkg::REM_W-1:0]  rem_q, rem_d;
  logic [wmv_pkg::RAMP_W-1:0] quo_q, quo_d;
  logic [wmv_pkg::N_W-1:0]    den_q, den_d;
  logic [wmv_pkg::REM_W-1:0]  rem2;

  assign rem2 = {rem_q[wmv_pkg::REM_W-2:0], 1'b0};

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    if (start_i) begin
      cnt_d = wmv_pkg::DCNT_W'(wmv_pkg::RAMP_W);
      rem_d = wmv_pkg::REM_W'(num_i);
      quo_d = '0;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (rem2 >= wmv_pkg::REM_W'(den_q)) begin
        rem_d = rem2 - wmv_pkg::REM_W'(den_q);
        quo_d = {quo_q[wmv_pkg::RAMP_W-2:0], 1'b1};
      end else begin
        rem_d = rem2;
        quo_d = {quo_q[wmv_pkg::RAMP_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;

endmodule

>>> src/wmv_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmv_mac
// Shared signed multiply-accumulate unit: registered product, then
// accumulate (or restart) in the following cycle.
// ----------------------------------------------------------------------------
module wmv_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wmv_pkg::wmv_mac_cmd_t               cmd_i,
  output logic signed [wmv_pkg::ACC_W-1:0]    acc_o
);

  logic                                 en_q;
  logic                                 clr_q;
  logic signed [wmv_pkg::PROD_W-1:0]    prod_q;
  logic signed [wmv_pkg::ACC_W-1:0]     acc_q;
  logic signed [wmv_pkg::ACC_W-1:0]     prod_ext;
  logic signed [wmv_pkg::ACC_W-1:0]     acc_base;

  assign prod_ext = {{(wmv_pkg::ACC_W - wmv_pkg::PROD_W){prod_q[wmv_pkg::PROD_W-1]}}, prod_q};
  assign acc_base = clr_q ? '0 : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b0;
      clr_q <= 1'b0;
    end else begin
      en_q  <= cmd_i.en;
      clr_q <= cmd_i.clr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.en) begin
      prod_q <= cmd_i.a * cmd_i.b;
    end
    if (en_q) begin
      acc_q <= acc_base + prod_ext;
    end
  end

  assign acc_o = acc_q;

endmodule
